### rtl/core/rpsc_pkg.sv
package rpsc_pkg;

  // Field widths.
  localparam int LenW   = 16;
  localparam int LimW   = 13;
  localparam int PerW   = 6;
  localparam int ThrW   = 5;
  localparam int WinW   = 6;
  localparam int HitW   = 8;
  localparam int DivW   = 7;
  localparam int SelW   = 2;
  localparam int IdxW   = 2;
  localparam int CfgW   = 6;

  // Register indexes on the configuration port.
  localparam logic [IdxW-1:0] REG_CARRIER_PERIOD = 2'd0;
  localparam logic [IdxW-1:0] REG_ERROR_THRESHOLD = 2'd1;
  localparam logic [IdxW-1:0] REG_PULSE_WINDOW = 2'd2;

  // Register reset values.
  localparam logic [PerW-1:0] CARRIER_PERIOD_RESET = 6'd8;
  localparam logic [ThrW-1:0] ERROR_THRESHOLD_RESET = 5'd10;
  localparam logic [WinW-1:0] PULSE_WINDOW_RESET = 6'd50;

  // Divider selector codes.
  localparam logic [SelW-1:0] DIV_SEL_16 = 2'd0;
  localparam logic [SelW-1:0] DIV_SEL_32 = 2'd1;
  localparam logic [SelW-1:0] DIV_SEL_64 = 2'd2;

  // Event kinds.
  localparam logic EV_SYNC = 1'b0;
  localparam logic EV_PULSE = 1'b1;

  // Sync acquisition limits.
  localparam logic [HitW-1:0] SYNC_MIN_HITS = 8'd4;
  localparam logic [ThrW-1:0] SYNC_MAX_BAD = 5'd4;
  localparam logic [HitW-1:0] HIT_MAX = 8'hFF;
  localparam logic [ThrW-1:0] BAD_MAX = 5'h1F;

  typedef struct packed {
    logic [PerW-1:0] carrier_period_us;
    logic [ThrW-1:0] error_threshold;
    logic [WinW-1:0] pulse_window;
  } cfg_t;

  typedef struct packed {
    logic [LimW-1:0] short_min;
    logic [LimW-1:0] short_max;
    logic [LimW-1:0] long_min;
    logic [LimW-1:0] long_max;
  } limits_t;

  typedef struct packed {
    logic            event_kind;
    logic            sync_flag;
    logic [DivW-1:0] divider_value;
    logic            level_high;
    logic            long_pulse;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

  // Divider value for a selector code; the unused code reads as 16.
  function automatic logic [DivW-1:0] divider_of(input logic [SelW-1:0] sel);
    logic [DivW-1:0] d;
    case (sel)
      DIV_SEL_32: d = 7'd32;
      DIV_SEL_64: d = 7'd64;
      default:    d = 7'd16;
    endcase
    return d;
  endfunction

  // Next divider in the order 16, 32, 64 and back to 16; the unused code also leads to 16.
  function automatic logic [SelW-1:0] next_sel(input logic [SelW-1:0] sel);
    logic [SelW-1:0] n;
    case (sel)
      DIV_SEL_16: n = DIV_SEL_32;
      DIV_SEL_32: n = DIV_SEL_64;
      default:    n = DIV_SEL_16;
    endcase
    return n;
  endfunction

  // Classification windows. The nominal length is divider * period / 2,
  // which is a shift since the divider is a power of two.
  function automatic limits_t limits_for(input logic [SelW-1:0] sel,
                                         input logic [PerW-1:0] cp);
    logic [LimW-1:0] nom;
    logic [LimW-1:0] tol;
    limits_t         l;
    case (sel)
      DIV_SEL_32: nom = {3'b0, cp, 4'b0};
      DIV_SEL_64: nom = {2'b0, cp, 5'b0};
      default:    nom = {4'b0, cp, 3'b0};
    endcase
    tol = nom >> 2;
    l.short_min = nom - tol;
    l.short_max = nom + tol;
    l.long_min = (nom << 1) - tol;
    l.long_max = (nom << 1) + tol;
    return l;
  endfunction

endpackage

### rtl/core/rpsc_pulse_if.sv
interface rpsc_pulse_if;
  logic                        valid;
  logic                        ready;
  logic [rpsc_pkg::LenW-1:0]   length_us;
  logic                        is_low;

  modport source (output valid, output length_us, output is_low, input ready);
  modport sink (input valid, input length_us, input is_low, output ready);
endinterface

### rtl/core/rpsc_event_if.sv
interface rpsc_event_if;
  logic                        valid;
  logic                        ready;
  logic                        event_kind;
  logic                        sync_flag;
  logic [rpsc_pkg::DivW-1:0]   divider_value;
  logic                        level_high;
  logic                        long_pulse;

  modport source (output valid, output event_kind, output sync_flag,
                  output divider_value, output level_high, output long_pulse,
                  input ready);
  modport sink (input valid, input event_kind, input sync_flag,
                input divider_value, input level_high, input long_pulse,
                output ready);
endinterface

### rtl/core/rpsc_cfg_regs.sv
module rpsc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rpsc_pkg::IdxW-1:0] cfg_index,
  input  logic [rpsc_pkg::CfgW-1:0] cfg_data,
  output rpsc_pkg::cfg_t            cfg
);

  // Register file; writes to an index past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_period_us <= rpsc_pkg::CARRIER_PERIOD_RESET;
      cfg.error_threshold <= rpsc_pkg::ERROR_THRESHOLD_RESET;
      cfg.pulse_window <= rpsc_pkg::PULSE_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rpsc_pkg::REG_CARRIER_PERIOD: begin
          cfg.carrier_period_us <= cfg_data[rpsc_pkg::PerW-1:0];
        end
        rpsc_pkg::REG_ERROR_THRESHOLD: begin
          cfg.error_threshold <= cfg_data[rpsc_pkg::ThrW-1:0];
        end
        rpsc_pkg::REG_PULSE_WINDOW: begin
          cfg.pulse_window <= cfg_data[rpsc_pkg::WinW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/rpsc_core.sv
module rpsc_core (
  input  logic                      clk,
  input  logic                      rst,
  input  rpsc_pkg::cfg_t            cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rpsc_pkg::LenW-1:0] length_us,
  input  logic                      is_low,
  input  logic                      room,
  output rpsc_pkg::push_t           push
);

  // Input register.
  logic                      held;
  logic [rpsc_pkg::LenW-1:0] len_r;
  logic                      low_r;
  logic                      advance;

  // Classifier state.
  logic [rpsc_pkg::SelW-1:0] divider_sel, divider_sel_next;
  logic                      in_sync, in_sync_next;
  logic [rpsc_pkg::HitW-1:0] short_hits, short_hits_next;
  logic [rpsc_pkg::HitW-1:0] long_hits, long_hits_next;
  logic [rpsc_pkg::ThrW-1:0] bad_hits, bad_hits_next;
  logic [rpsc_pkg::WinW-1:0] window_pos, window_pos_next;
  rpsc_pkg::limits_t         limits, limits_next;

  logic [rpsc_pkg::WinW-1:0] wp_inc;
  logic [rpsc_pkg::ThrW-1:0] bad_base;
  logic                      hit_short, hit_long;
  logic                      emit;
  rpsc_pkg::result_t         res;

  // An item moves on whenever the output buffer has room.
  assign advance = held && room;
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      len_r <= length_us;
      low_r <= is_low;
    end
  end

  // Window compares against the stored limits.
  assign hit_short = (len_r >= {3'b0, limits.short_min}) &&
                     (len_r <= {3'b0, limits.short_max});
  assign hit_long = (len_r >= {3'b0, limits.long_min}) &&
                    (len_r <= {3'b0, limits.long_max});

  // Per-pulse update and event selection.
  always_comb begin
    divider_sel_next = divider_sel;
    in_sync_next = in_sync;
    short_hits_next = short_hits;
    long_hits_next = long_hits;
    bad_hits_next = bad_hits;
    limits_next = limits;
    emit = 1'b0;
    res = '0;
    wp_inc = window_pos + 6'd1;
    window_pos_next = wp_inc;
    bad_base = bad_hits;

    if (bad_hits >= cfg.error_threshold) begin
      // Too many errors: drop sync and move to the next divider.
      in_sync_next = 1'b0;
      short_hits_next = '0;
      long_hits_next = '0;
      bad_hits_next = '0;
      window_pos_next = '0;
      divider_sel_next = rpsc_pkg::next_sel(divider_sel);
      limits_next = rpsc_pkg::limits_for(rpsc_pkg::next_sel(divider_sel),
                                         cfg.carrier_period_us);
      emit = 1'b1;
      res.event_kind = rpsc_pkg::EV_SYNC;
    end else begin
      // The error count is cleared once per pulse window.
      if (wp_inc == cfg.pulse_window) begin
        window_pos_next = '0;
        bad_base = '0;
      end
      bad_hits_next = bad_base;

      if (!in_sync) begin
        if (hit_short) begin
          if (short_hits != rpsc_pkg::HIT_MAX) begin
            short_hits_next = short_hits + 8'd1;
          end
        end else if (hit_long) begin
          if (long_hits != rpsc_pkg::HIT_MAX) begin
            long_hits_next = long_hits + 8'd1;
          end
        end else if (bad_base != rpsc_pkg::BAD_MAX) begin
          bad_hits_next = bad_base + 5'd1;
        end
        if ((long_hits_next > rpsc_pkg::SYNC_MIN_HITS) &&
            (short_hits_next > rpsc_pkg::SYNC_MIN_HITS) &&
            (bad_hits_next < rpsc_pkg::SYNC_MAX_BAD)) begin
          in_sync_next = 1'b1;
          emit = 1'b1;
          res.event_kind = rpsc_pkg::EV_SYNC;
          res.sync_flag = 1'b1;
          res.divider_value = rpsc_pkg::divider_of(divider_sel);
        end
      end else if (hit_long || hit_short) begin
        // Long is tested first while synced.
        emit = 1'b1;
        res.event_kind = rpsc_pkg::EV_PULSE;
        res.level_high = !low_r;
        res.long_pulse = hit_long;
      end else if (bad_base != rpsc_pkg::BAD_MAX) begin
        bad_hits_next = bad_base + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_sel <= rpsc_pkg::DIV_SEL_16;
      in_sync <= 1'b0;
      short_hits <= '0;
      long_hits <= '0;
      bad_hits <= '0;
      window_pos <= '0;
      limits <= rpsc_pkg::limits_for(rpsc_pkg::DIV_SEL_16,
                                     rpsc_pkg::CARRIER_PERIOD_RESET);
    end else if (advance) begin
      divider_sel <= divider_sel_next;
      in_sync <= in_sync_next;
      short_hits <= short_hits_next;
      long_hits <= long_hits_next;
      bad_hits <= bad_hits_next;
      window_pos <= window_pos_next;
      limits <= limits_next;
    end
  end

  assign push.valid = advance && emit;
  assign push.data = res;

endmodule

### rtl/core/rpsc_skid.sv
module rpsc_skid (
  input  logic              clk,
  input  logic              rst,
  input  rpsc_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output rpsc_pkg::result_t out_data
);

  logic              main_valid;
  logic              skid_valid;
  rpsc_pkg::result_t main_data;
  rpsc_pkg::result_t skid_data;
  logic              pop;

  // A new result is taken whenever the spare slot is free.
  assign room = !skid_valid;
  assign pop = main_valid && out_ready;
  assign out_valid = main_valid;
  assign out_data = main_data;

  // Control: the spare slot drains into the output register first.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push.valid) begin
      if (main_valid && !pop) begin
        skid_data <= push.data;
      end else begin
        main_data <= push.data;
      end
    end
  end

endmodule

### rtl/core/rfid_pulse_rate_sync_classifier.sv
// Pulse-rate sync classifier for a carrier-modulated RFID tag signal.
// The pulses channel takes one measured pulse per transfer: its length in
// microseconds and whether it was a low level. The events channel gives at
// most one event per pulse: a sync change (gained, with the divider, or
// lost, with divider 0) or, while synced, a pulse classified short or long.
// The configuration port sets the carrier period, the error threshold and
// the pulse window; write it only while no pulse is in flight.
// Throughput is one pulse per cycle while not stalled: the classifier is a
// single stage of compares and saturating counters behind an input
// register. An event passes through the input register and then the
// output register before it goes valid on the events channel. The output
// register and a spare slot decouple the two sides, so pulses keep flowing
// while one event waits; when both are full and a pulse waits in the input
// register, the pulses channel deasserts ready until the receiver takes an
// event. Reset returns the registers to period 8, threshold 10 and window
// 50, selects divider 16 unsynced with cleared counters, and empties the
// pipeline. A new carrier period takes effect at the next divider change.
module rfid_pulse_rate_sync_classifier (
  input  logic                      clk,
  input  logic                      rst,
  rpsc_pulse_if.sink                pulses,
  rpsc_event_if.source              events,
  input  logic                      cfg_we,
  input  logic [rpsc_pkg::IdxW-1:0] cfg_index,
  input  logic [rpsc_pkg::CfgW-1:0] cfg_data
);

  rpsc_pkg::cfg_t    cfg;
  rpsc_pkg::push_t   push;
  rpsc_pkg::result_t out_data;
  logic              room;
  logic              in_ready;
  logic              out_valid;

  rpsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpsc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pulses.valid),
    .in_ready  (in_ready),
    .length_us (pulses.length_us),
    .is_low    (pulses.is_low),
    .room      (room),
    .push      (push)
  );

  rpsc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (events.ready),
    .out_data  (out_data)
  );

  assign pulses.ready = in_ready;
  assign events.valid = out_valid;
  assign events.event_kind = out_data.event_kind;
  assign events.sync_flag = out_data.sync_flag;
  assign events.divider_value = out_data.divider_value;
  assign events.level_high = out_data.level_high;
  assign events.long_pulse = out_data.long_pulse;

endmodule

### rtl/core/rpsc_checker.sv
module rpsc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      valid,
  input logic                      ready,
  input logic                      event_kind,
  input logic                      sync_flag,
  input logic [rpsc_pkg::DivW-1:0] divider_value,
  input logic                      level_high,
  input logic                      long_pulse
);

  // A stalled event keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable({event_kind, sync_flag, divider_value,
                                          level_high, long_pulse}))
    else $error("stalled event changed");

  // The pipeline is empty right after reset.
  assert property (@(posedge clk) rst |=> !valid)
    else $error("event valid after reset");

  // Pulse events carry no sync information.
  assert property (@(posedge clk) disable iff (rst)
    valid && event_kind == rpsc_pkg::EV_PULSE |-> !sync_flag && divider_value == '0)
    else $error("pulse event with sync fields set");

  // Sync gained reports a real divider; sync lost reports zero and no pulse data.
  assert property (@(posedge clk) disable iff (rst)
    valid && event_kind == rpsc_pkg::EV_SYNC && sync_flag |->
      divider_value == 7'd16 || divider_value == 7'd32 || divider_value == 7'd64)
    else $error("sync gained with bad divider");

  assert property (@(posedge clk) disable iff (rst)
    valid && event_kind == rpsc_pkg::EV_SYNC && !sync_flag |->
      divider_value == '0 && !level_high && !long_pulse)
    else $error("sync lost event with stray fields");

endmodule

bind rfid_pulse_rate_sync_classifier rpsc_checker u_rpsc_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (events.valid),
  .ready         (events.ready),
  .event_kind    (events.event_kind),
  .sync_flag     (events.sync_flag),
  .divider_value (events.divider_value),
  .level_high    (events.level_high),
  .long_pulse    (events.long_pulse)
);
